// ===== hw/rtl/avn_pkg.sv =====
`default_nettype none

package avn_pkg;

	// Width of a magnitude between the offset stage and the normalizer.
	localparam int MAG_W = 62;
	// Width of a normalized magnitude (largest one lies in [2^29, 2^30)).
	localparam int NRM_W = 30;
	// Number of binary shift steps in each direction of the normalizer.
	localparam int SH_STEPS = 5;
	// Width of one output normal component.
	localparam int NORM_WIDTH = 16;

	// Register indexes of the configuration port.
	typedef enum logic [2:0] {
		REG_MODE   = 3'd0,
		REG_CEN_X  = 3'd1,
		REG_CEN_Y  = 3'd2,
		REG_CEN_Z  = 3'd3,
		REG_SIZE_X = 3'd4,
		REG_SIZE_Y = 3'd5,
		REG_SIZE_Z = 3'd6
	} reg_idx_t;

	// Abstraction modes; the fourth code has no meaning and yields a degenerate item.
	localparam logic [1:0] MODE_SPHERIC   = 2'd0;
	localparam logic [1:0] MODE_ELLIPTIC  = 2'd1;
	localparam logic [1:0] MODE_CYLINDRIC = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/avn_div.sv =====
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// The upper NW-QW numerator bits must be below the divisor.
module avn_div #(
	parameter int NW = 62,
	parameter int QW = 62,
	parameter int DW = 31,
	parameter int TW = 2
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	input  wire logic [TW-1:0] in_tag,
	output logic               out_valid,
	output logic [QW-1:0]      quo,
	output logic [TW-1:0]      out_tag
);

	logic [DW-1:0] rem_in;
	logic [DW-1:0] rem_s[0:QW];
	logic [QW-1:0] lo_s[0:QW];
	logic [QW-1:0] quo_s[0:QW];
	logic [DW-1:0] den_s[0:QW];
	logic [TW-1:0] tag_s[0:QW];
	logic          vld_s[0:QW];
	logic [DW:0]   trial[QW];
	logic          ge[QW];
	logic [DW-1:0] nrem[QW];

	// Partial remainder that enters the first stage.
	generate
		if (QW < NW) begin : g_top
			assign rem_in = DW'(num[NW-1:QW]);
		end else begin : g_zero
			assign rem_in = '0;
		end
	endgenerate

	// One trial subtraction per stage.
	always_comb begin
		for (int k = 0; k < QW; k++) begin
			trial[k] = {rem_s[k], lo_s[k][QW-1]};
			ge[k]    = trial[k] >= {1'b0, den_s[k]};
			nrem[k]  = ge[k] ? DW'(trial[k] - {1'b0, den_s[k]}) : trial[k][DW-1:0];
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QW; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 0; k < QW; k++) vld_s[k+1] <= vld_s[k];
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= rem_in;
			lo_s[0]  <= num[QW-1:0];
			quo_s[0] <= '0;
			den_s[0] <= den;
			tag_s[0] <= in_tag;
			for (int k = 0; k < QW; k++) begin
				rem_s[k+1] <= nrem[k];
				lo_s[k+1]  <= lo_s[k] << 1;
				quo_s[k+1] <= {quo_s[k][QW-2:0], ge[k]};
				den_s[k+1] <= den_s[k];
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign quo       = quo_s[QW];
	assign out_tag   = tag_s[QW];

endmodule

`default_nettype wire

// ===== hw/rtl/avn_sqrt.sv =====
`default_nettype none

// Pipelined integer square root, one root bit per stage.
module avn_sqrt #(
	parameter int XW = 62,
	parameter int TW = 94
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [XW-1:0] x,
	input  wire logic [TW-1:0] in_tag,
	output logic               out_valid,
	output logic [XW/2-1:0]    root,
	output logic [TW-1:0]      out_tag
);

	localparam int HW = XW / 2;

	logic [XW-1:0] x_s[0:HW];
	logic [XW-1:0] r_s[0:HW];
	logic [TW-1:0] tag_s[0:HW];
	logic          vld_s[0:HW];
	logic [XW-1:0] nx[HW];
	logic [XW-1:0] nr[HW];

	// Each stage tries one bit of the root.
	always_comb begin
		logic [XW-1:0] bitv;
		logic [XW:0]   sum;
		logic          ge;
		for (int k = 0; k < HW; k++) begin
			bitv  = XW'(1) << (XW - 2 - 2 * k);
			sum   = {1'b0, r_s[k]} + {1'b0, bitv};
			ge    = {1'b0, x_s[k]} >= sum;
			nx[k] = ge ? XW'({1'b0, x_s[k]} - sum) : x_s[k];
			nr[k] = ge ? (r_s[k] >> 1) + bitv : r_s[k] >> 1;
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= HW; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 0; k < HW; k++) vld_s[k+1] <= vld_s[k];
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]   <= x;
			r_s[0]   <= '0;
			tag_s[0] <= in_tag;
			for (int k = 0; k < HW; k++) begin
				x_s[k+1]   <= nx[k];
				r_s[k+1]   <= nr[k];
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign out_valid = vld_s[HW];
	assign root      = r_s[HW][HW-1:0];
	assign out_tag   = tag_s[HW];

endmodule

`default_nettype wire

// ===== hw/rtl/abstract_vertex_normal.sv =====
// Abstract vertex normal for toon shading.
// Configuration: write mode, box center and box size over the cfg channel
// (cfg_valid, cfg_index, cfg_data); cfg_ready is always high. Write only while
// no item is in flight.
// Input channel: in_valid / in_stall with pos_x, pos_y, pos_z (Q16.16).
// Output channel: out_valid / out_stall with norm_x, norm_y, norm_z (Q1.14)
// and degenerate. One result item per input item, in order.
// Throughput: one item per cycle while the output is not stalled. The path
// from the accepting edge to out_valid runs through the bit-per-stage elliptic
// divider (63 registers), the normalizer (11), the square stage (1), the
// square root (32), the final divider (NORMAL_FRAC + 2) and the output
// register; the accepting edge loads the first of them.
// A stall while out_valid is high freezes the whole pipeline and raises
// in_stall in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and loads mode spheric, center zero and box
// size 1.0 on every axis.
`default_nettype none

module abstract_vertex_normal #(
	parameter int COORD_WIDTH = 32,
	parameter int NORMAL_FRAC = 14
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [2:0]                            cfg_index,
	input  wire logic [COORD_WIDTH-1:0]                cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [COORD_WIDTH-1:0]         pos_x,
	input  wire logic signed [COORD_WIDTH-1:0]         pos_y,
	input  wire logic signed [COORD_WIDTH-1:0]         pos_z,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed [avn_pkg::NORM_WIDTH-1:0]      norm_x,
	output logic signed [avn_pkg::NORM_WIDTH-1:0]      norm_y,
	output logic signed [avn_pkg::NORM_WIDTH-1:0]      norm_z,
	output logic                                       degenerate
);

	import avn_pkg::*;

	localparam int CW        = COORD_WIDTH;
	localparam int NF        = NORMAL_FRAC;
	localparam int ELL_SHIFT = 61 - CW;
	localparam int SZ_W      = CW - 1;
	localparam int SH        = 2 * SH_STEPS;
	localparam int LEN_W     = MAG_W / 2;
	localparam int FQ_W      = NF + 1;
	localparam int FN_W      = NRM_W + NF + 1;
	localparam int STAG_W    = 3 * NRM_W + 4;

	logic [1:0]            mode_q;
	logic signed [CW-1:0]  cen_q[3];
	logic [SZ_W-1:0]       size_q[3];
	logic                  en;
	logic signed [CW-1:0]  pos_a[3];
	logic [MAG_W-1:0]      num_in[3];
	logic [SZ_W-1:0]       den_in[3];
	logic [2:0]            neg_in;
	logic                  dgn_in;
	logic [1:0]            ax;
	logic [2:0]            ev;
	logic [MAG_W-1:0]      eq[3];
	logic [1:0]            etag[3];
	logic [MAG_W-1:0]      emax;
	logic [MAG_W-1:0]      mag_s2[0:SH][3];
	logic [MAG_W-1:0]      max_s2[0:SH];
	logic [2:0]            neg_s2[0:SH];
	logic                  dgn_s2[0:SH];
	logic                  vld_s2[0:SH];
	logic [NRM_W-1:0]      m_s3[3];
	logic [2*NRM_W-1:0]    sq_s3[3];
	logic [2:0]            neg_s3;
	logic                  dgn_s3;
	logic                  vld_s3;
	logic [MAG_W-1:0]      sq_sum;
	logic                  rv;
	logic [LEN_W-1:0]      len;
	logic [STAG_W-1:0]     rtag;
	logic [NRM_W-1:0]      rm[3];
	logic [2:0]            rneg;
	logic                  rdgn;
	logic [FN_W-1:0]       fnum[3];
	logic [2:0]            fv;
	logic [FQ_W-1:0]       fq[3];
	logic [1:0]            ftag[3];
	logic [NORM_WIDTH-1:0] nval[3];
	logic [NORM_WIDTH-1:0] norm_s4[3];
	logic                  dgn_s4;
	logic                  vld_s4;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SPHERIC;
			for (int i = 0; i < 3; i++) begin
				cen_q[i]  <= '0;
				size_q[i] <= SZ_W'(65536);
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MODE:   mode_q    <= cfg_data[1:0];
				REG_CEN_X:  cen_q[0]  <= cfg_data;
				REG_CEN_Y:  cen_q[1]  <= cfg_data;
				REG_CEN_Z:  cen_q[2]  <= cfg_data;
				REG_SIZE_X: size_q[0] <= cfg_data[SZ_W-1:0];
				REG_SIZE_Y: size_q[1] <= cfg_data[SZ_W-1:0];
				REG_SIZE_Z: size_q[2] <= cfg_data[SZ_W-1:0];
				default:    ;
			endcase
		end
	end

	// The whole pipeline moves unless a finished item waits on a stalled receiver.
	assign en       = !(vld_s4 && out_stall);
	assign in_stall = !en;

	assign pos_a[0] = pos_x;
	assign pos_a[1] = pos_y;
	assign pos_a[2] = pos_z;

	// Offsets from the center and the divider operands for the chosen mode.
	always_comb begin
		logic signed [CW:0] d;
		logic [CW:0]        mg;
		if (size_q[0] > size_q[1] && size_q[0] > size_q[2]) begin
			ax = 2'd0;
		end else if (size_q[1] > size_q[0] && size_q[1] > size_q[2]) begin
			ax = 2'd1;
		end else begin
			ax = 2'd2;
		end
		dgn_in = (mode_q != MODE_SPHERIC && mode_q != MODE_ELLIPTIC &&
			mode_q != MODE_CYLINDRIC) || (mode_q == MODE_ELLIPTIC &&
			(size_q[0] == '0 || size_q[1] == '0 || size_q[2] == '0));
		for (int i = 0; i < 3; i++) begin
			d         = {pos_a[i][CW-1], pos_a[i]} - {cen_q[i][CW-1], cen_q[i]};
			neg_in[i] = d[CW];
			mg        = d[CW] ? (CW+1)'(-d) : d;
			if (mode_q == MODE_ELLIPTIC) begin
				num_in[i] = {mg, {ELL_SHIFT{1'b0}}};
				den_in[i] = (size_q[i] != '0) ? size_q[i] : SZ_W'(1);
			end else begin
				num_in[i] = MAG_W'(mg);
				den_in[i] = SZ_W'(1);
				if (mode_q == MODE_CYLINDRIC && ax == 2'(i)) num_in[i] = '0;
			end
		end
	end

	// Elliptic scaling; other modes divide by one.
	for (genvar g = 0; g < 3; g++) begin : g_ell
		avn_div #(.NW(MAG_W), .QW(MAG_W), .DW(SZ_W), .TW(2)) u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (in_valid),
			.num       (num_in[g]),
			.den       (den_in[g]),
			.in_tag    ({neg_in[g], dgn_in}),
			.out_valid (ev[g]),
			.quo       (eq[g]),
			.out_tag   (etag[g])
		);
	end

	// Largest magnitude drives the common normalizing shift.
	always_comb begin
		emax = eq[0];
		if (eq[1] > emax) emax = eq[1];
		if (eq[2] > emax) emax = eq[2];
	end

	// Normalizer valid bits: entry stage, then one stage per shift step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= SH; k++) vld_s2[k] <= 1'b0;
		end else if (en) begin
			vld_s2[0] <= &ev;
			for (int k = 0; k < SH; k++) vld_s2[k+1] <= vld_s2[k];
		end
	end

	// Right shifts bring the largest below 2^30, then left shifts lift it to 2^29.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) mag_s2[0][i] <= eq[i];
			max_s2[0] <= emax;
			neg_s2[0] <= {etag[2][1], etag[1][1], etag[0][1]};
			dgn_s2[0] <= etag[0][0] | etag[1][0] | etag[2][0] | (emax == '0);
			for (int k = 0; k < SH_STEPS; k++) begin
				if (max_s2[k] >= (MAG_W'(1) << (NRM_W - 1 + (16 >> k)))) begin
					for (int i = 0; i < 3; i++) mag_s2[k+1][i] <= mag_s2[k][i] >> (16 >> k);
					max_s2[k+1] <= max_s2[k] >> (16 >> k);
				end else begin
					for (int i = 0; i < 3; i++) mag_s2[k+1][i] <= mag_s2[k][i];
					max_s2[k+1] <= max_s2[k];
				end
				neg_s2[k+1] <= neg_s2[k];
				dgn_s2[k+1] <= dgn_s2[k];
			end
			for (int k = 0; k < SH_STEPS; k++) begin
				if (max_s2[k+SH_STEPS] < (MAG_W'(1) << (NRM_W - (16 >> k)))) begin
					for (int i = 0; i < 3; i++) begin
						mag_s2[k+SH_STEPS+1][i] <= mag_s2[k+SH_STEPS][i] << (16 >> k);
					end
					max_s2[k+SH_STEPS+1] <= max_s2[k+SH_STEPS] << (16 >> k);
				end else begin
					for (int i = 0; i < 3; i++) begin
						mag_s2[k+SH_STEPS+1][i] <= mag_s2[k+SH_STEPS][i];
					end
					max_s2[k+SH_STEPS+1] <= max_s2[k+SH_STEPS];
				end
				neg_s2[k+SH_STEPS+1] <= neg_s2[k+SH_STEPS];
				dgn_s2[k+SH_STEPS+1] <= dgn_s2[k+SH_STEPS];
			end
		end
	end

	// Squares of the normalized magnitudes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2[SH];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				m_s3[i]  <= mag_s2[SH][i][NRM_W-1:0];
				sq_s3[i] <= mag_s2[SH][i][NRM_W-1:0] * mag_s2[SH][i][NRM_W-1:0];
			end
			neg_s3 <= neg_s2[SH];
			dgn_s3 <= dgn_s2[SH];
		end
	end

	assign sq_sum = MAG_W'(sq_s3[0]) + MAG_W'(sq_s3[1]) + MAG_W'(sq_s3[2]);

	// Vector length.
	avn_sqrt #(.XW(MAG_W), .TW(STAG_W)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s3),
		.x         (sq_sum),
		.in_tag    ({m_s3[0], m_s3[1], m_s3[2], neg_s3, dgn_s3}),
		.out_valid (rv),
		.root      (len),
		.out_tag   (rtag)
	);

	assign {rm[0], rm[1], rm[2], rneg, rdgn} = rtag;

	// Rounded component division by the length.
	for (genvar g = 0; g < 3; g++) begin : g_nrm
		assign fnum[g] = FN_W'({rm[g], {NF{1'b0}}}) + FN_W'(len >> 1);

		avn_div #(.NW(FN_W), .QW(FQ_W), .DW(LEN_W), .TW(2)) u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (rv),
			.num       (fnum[g]),
			.den       (len),
			.in_tag    ({rneg[g], rdgn}),
			.out_valid (fv[g]),
			.quo       (fq[g]),
			.out_tag   (ftag[g])
		);
	end

	// Clamp to one and apply the offset sign.
	always_comb begin
		logic [FQ_W-1:0]        nn;
		logic signed [FQ_W:0]   sv;
		logic signed [63:0]     wide;
		for (int i = 0; i < 3; i++) begin
			nn      = (fq[i] > (FQ_W'(1) << NF)) ? (FQ_W'(1) << NF) : fq[i];
			sv      = ftag[i][1] ? -$signed({1'b0, nn}) : $signed({1'b0, nn});
			wide    = $signed({{(64 - FQ_W - 1){sv[FQ_W]}}, sv});
			nval[i] = wide[NORM_WIDTH-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= &fv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dgn_s4 <= ftag[0][0] | ftag[1][0] | ftag[2][0];
			for (int i = 0; i < 3; i++) begin
				norm_s4[i] <= (ftag[0][0] | ftag[1][0] | ftag[2][0]) ? '0 : nval[i];
			end
		end
	end

	assign out_valid  = vld_s4;
	assign norm_x     = norm_s4[0];
	assign norm_y     = norm_s4[1];
	assign norm_z     = norm_s4[2];
	assign degenerate = dgn_s4;

	// A degenerate item carries a zero normal.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> norm_x == '0 && norm_y == '0 && norm_z == '0)
		else $error("degenerate item with a nonzero normal");

	// A regular item always has some direction.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !degenerate |-> norm_x != '0 || norm_y != '0 || norm_z != '0)
		else $error("regular item with a zero normal");

	// The input side is held only while a finished item waits.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a waiting item");

endmodule

`default_nettype wire
